/* hdl/aes_pkg.sv */
`timescale 1ns / 1ps
package aes_pkg;

	localparam int KEY_WORDS = 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_ROUND,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		REG_KEY0 = 3'd0,
		REG_KEY1 = 3'd1,
		REG_KEY2 = 3'd2,
		REG_KEY3 = 3'd3,
		REG_IV_HIGH = 3'd4,
		REG_IV_LOW = 3'd5
	} reg_idx_t;

	// Control from the sequencer to the round lanes
	typedef struct packed {
		logic load;
		logic step;
		logic last;
	} lane_ctl_t;

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		p = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p = p ^ x;
			x = xtime(x);
		end
		gf_mul = p;
	endfunction

	function automatic logic [7:0] sbox_calc(input logic [7:0] x);
		logic [7:0] inv;
		logic [7:0] base;
		logic [7:0] e;
		inv = 8'h01;
		base = x;
		e = 8'd254;
		for (int i = 0; i < 8; i++) begin
			if (e[i]) inv = gf_mul(inv, base);
			base = gf_mul(base, base);
		end
		if (x == 8'h00) inv = 8'h00;
		sbox_calc = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
			^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
	endfunction

	typedef logic [7:0] sbox_tab_t [256];

	function automatic sbox_tab_t make_sbox();
		sbox_tab_t t;
		for (int i = 0; i < 256; i++) t[i] = sbox_calc(8'(i));
		make_sbox = t;
	endfunction

	localparam sbox_tab_t SBOX = make_sbox();

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

endpackage

/* hdl/aes_ram.sv */
`timescale 1ns / 1ps
module aes_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/aes_lane.sv */
`timescale 1ns / 1ps
module aes_lane import aes_pkg::*; (
	input  logic        clk,
	input  lane_ctl_t   ctl,
	input  logic [31:0] init_col,
	input  logic [31:0] key_col,
	input  logic [31:0] sr_col,
	output logic [31:0] sub_col,
	output logic [31:0] state_col
);

	logic [31:0] col_q;
	logic [31:0] mixed;
	logic [7:0]  a0, a1, a2, a3, sum;

	// SubBytes on this lane's stored column
	assign sub_col = sub_word(col_q);
	assign state_col = col_q;

	// MixColumns on the shifted column
	always_comb begin
		a0 = sr_col[31:24];
		a1 = sr_col[23:16];
		a2 = sr_col[15:8];
		a3 = sr_col[7:0];
		sum = a0 ^ a1 ^ a2 ^ a3;
		mixed = {a0 ^ sum ^ xtime(a0 ^ a1), a1 ^ sum ^ xtime(a1 ^ a2),
			a2 ^ sum ^ xtime(a2 ^ a3), a3 ^ sum ^ xtime(a3 ^ a0)};
	end

	// Load with whitening, run one round on a step, else hold
	always_ff @(posedge clk) begin
		if (ctl.load) col_q <= init_col ^ key_col;
		else if (ctl.step) begin
			if (ctl.last) col_q <= sr_col ^ key_col;
			else col_q <= mixed ^ key_col;
		end
	end

endmodule

/* hdl/aes_keyexp.sv */
`timescale 1ns / 1ps
module aes_keyexp import aes_pkg::*; (
	input  logic         clk,
	input  logic         load,
	input  logic [255:0] key,
	input  logic [2:0]   word_sel,
	output logic [31:0]  word
);

	logic [255:0] win_q;
	logic [7:0]   rcon_q;
	logic [31:0]  t;
	logic [31:0]  nw;
	logic [31:0]  last;

	// Window of the last eight schedule words, newest at the low end
	assign last = win_q[31:0];

	always_comb begin
		if (word_sel == 3'd0) t = sub_word({last[23:0], last[31:24]}) ^ {rcon_q, 24'h0};
		else if (word_sel == 3'd4) t = sub_word(last);
		else t = last;
		nw = win_q[255:224] ^ t;
	end

	assign word = nw;

	// Load the key or shift in one new word a cycle
	always_ff @(posedge clk) begin
		if (load) begin
			win_q <= key;
			rcon_q <= 8'h01;
		end else begin
			win_q <= {win_q[223:0], nw};
			if (word_sel == 3'd0) rcon_q <= xtime(rcon_q);
		end
	end

endmodule

/* hdl/aes256_ctr_cipher_core.sv */
`timescale 1ns / 1ps
// AES-256 counter-mode core. One 16-byte chunk per beat; result_bytes echoes
// chunk_bytes and bytes past the valid count (capped at 16) read as zero.
// Each round key is read from the round-key RAM as two 64-bit halves, high
// half first; after the first fetch the four column lanes load the whitened
// counter and then run each of the fourteen rounds as the low half of a round
// key arrives. The next chunk can be accepted in the cycle after the result
// beat, not before. A start beat first expands the key, one schedule word per
// cycle. Round keys live in a 30x64 RAM written by start.
module aes256_ctr_cipher_core import aes_pkg::*; #(
	parameter int ROUND_COUNT = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] chunk_high,
	input  logic [63:0] chunk_low,
	input  logic [4:0]  chunk_bytes,
	input  logic        start_req,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result_high,
	output logic [63:0] result_low,
	output logic [4:0]  result_bytes
);

	localparam int DEPTH = 2 * (ROUND_COUNT + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int SCHED = 4 * (ROUND_COUNT + 1);
	localparam int WCW = $clog2(SCHED + 1);
	localparam int RW = $clog2(ROUND_COUNT + 2);

	state_t state_q, state_d;
	logic [63:0] key_q [4];
	logic [63:0] iv_hi_q, iv_lo_q, ctr_hi_q, ctr_lo_q;
	logic [63:0] dhi_q, dlo_q;
	logic [4:0]  nb_q;
	logic [WCW-1:0] wc_q;
	logic [RW-1:0]  rnd_q;
	logic        phase_q;
	logic [31:0] wlo_q;
	logic [31:0] kword;
	logic        ram_we;
	logic [AW-1:0] waddr, raddr;
	logic [63:0] wdata, rdata, rk_hi_q;
	logic        ke_load;
	lane_ctl_t   lctl;
	logic [31:0] init_c [4], key_c [4], sub_c [4], sr_c [4], st_c [4];
	logic [127:0] ctr_w, rk_w;
	logic [127:0] ks, mask, res;
	logic [4:0]  ncap;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_IDLE);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			iv_hi_q <= '0;
			iv_lo_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_KEY0: key_q[0] <= cfg_data;
				REG_KEY1: key_q[1] <= cfg_data;
				REG_KEY2: key_q[2] <= cfg_data;
				REG_KEY3: key_q[3] <= cfg_data;
				REG_IV_HIGH: iv_hi_q <= cfg_data;
				REG_IV_LOW: iv_lo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Key expansion: words 8.. come from the unit, first eight from the key;
	// load the unit on the last key word so it starts at word 8
	assign ke_load = (state_q == ST_EXPAND) && wc_q == WCW'(KEY_WORDS - 1);
	aes_keyexp u_keyexp (
		.clk(clk), .load(ke_load),
		.key({key_q[0], key_q[1], key_q[2], key_q[3]}),
		.word_sel(wc_q[2:0]), .word(kword)
	);

	always_comb begin
		if (wc_q < WCW'(KEY_WORDS))
			wdata = {wlo_q, key_q[wc_q[2:1]][31:0]};
		else
			wdata = {wlo_q, kword};
		ram_we = (state_q == ST_EXPAND) && wc_q[0];
		waddr = AW'(wc_q >> 1);
	end

	// Round key read: the high half is fetched first, the low half next
	assign raddr = AW'({rnd_q, phase_q});
	aes_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:
				if (in_valid) state_d = start_req ? ST_EXPAND : ST_ROUND;
			ST_EXPAND:
				if (wc_q == WCW'(SCHED - 1)) state_d = ST_ROUND;
			ST_ROUND:
				if (rnd_q == RW'(ROUND_COUNT + 1) && phase_q) state_d = ST_DONE;
			ST_DONE:
				if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wc_q <= '0;
			rnd_q <= '0;
			phase_q <= 1'b0;
			ctr_hi_q <= '0;
			ctr_lo_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					wc_q <= '0;
					rnd_q <= '0;
					phase_q <= 1'b0;
					if (in_valid && start_req) begin
						ctr_hi_q <= iv_hi_q;
						ctr_lo_q <= iv_lo_q;
					end
				end
				ST_EXPAND: wc_q <= wc_q + 1'b1;
				ST_ROUND: begin
					phase_q <= ~phase_q;
					if (phase_q) rnd_q <= rnd_q + 1'b1;
				end
				ST_DONE:
					if (out_ready) {ctr_hi_q, ctr_lo_q} <= {ctr_hi_q, ctr_lo_q} + 128'd1;
				default: ;
			endcase
		end
	end

	// Payload capture and key-word pairing
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dhi_q <= chunk_high;
			dlo_q <= chunk_low;
			nb_q <= chunk_bytes;
		end
		if (state_q == ST_EXPAND && !wc_q[0])
			wlo_q <= (wc_q < WCW'(KEY_WORDS)) ? key_q[wc_q[2:1]][63:32] : kword;
		if (phase_q) rk_hi_q <= rdata;
	end

	// Lanes load (whitening) or step when the low half of a round key arrives
	assign lctl.load = (state_q == ST_ROUND) && !phase_q && rnd_q == RW'(1);
	assign lctl.step = (state_q == ST_ROUND) && !phase_q;
	assign lctl.last = rnd_q == RW'(ROUND_COUNT + 1);
	assign ctr_w = {ctr_hi_q, ctr_lo_q};
	assign rk_w = {rk_hi_q, rdata};
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			init_c[c] = ctr_w[127 - 32 * c -: 32];
			key_c[c] = rk_w[127 - 32 * c -: 32];
			for (int r = 0; r < 4; r++)
				sr_c[c][31 - 8 * r -: 8] = sub_c[(c + r) % 4][31 - 8 * r -: 8];
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_lane
		aes_lane u_lane (
			.clk(clk), .ctl(lctl),
			.init_col(init_c[g]), .key_col(key_c[g]), .sr_col(sr_c[g]),
			.sub_col(sub_c[g]), .state_col(st_c[g])
		);
	end

	// Merge lanes into the keystream and mask the data
	assign ks = {st_c[0], st_c[1], st_c[2], st_c[3]};
	assign ncap = (nb_q > 5'd16) ? 5'd16 : nb_q;
	always_comb begin
		for (int i = 0; i < 16; i++)
			mask[127 - 8 * i -: 8] = (5'(i) < ncap) ? 8'hff : 8'h00;
		res = ({dhi_q, dlo_q} ^ ks) & mask;
	end

	assign out_valid = (state_q == ST_DONE);
	assign result_high = res[127:64];
	assign result_low = res[63:0];
	assign result_bytes = nb_q;

endmodule

/* bench/tb_aes256_ctr_cipher_core.sv */
`timescale 1ns / 1ps
module tb_aes256_ctr_cipher_core;
	import aes_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
		logic [4:0]  nb;
		logic        st;
	} chunk_t;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
		logic [4:0]  nb;
	} cipher_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [63:0] chunk_high = '0;
	logic [63:0] chunk_low = '0;
	logic [4:0]  chunk_bytes = 5'd16;
	logic        start_req = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] result_high;
	logic [63:0] result_low;
	logic [4:0]  result_bytes;

	aes256_ctr_cipher_core i_dut (.*);

	// Clock: 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	chunk_t      chunk_q[$];
	cipher_out_t cipher_q[$];
	int          in_idle = 0;
	int          out_idle = 0;
	int          mismatches = 0;
	int          cycles = 0;
	logic        in_fire = 1'b0;

	// Shadow registers and predictor state
	logic [63:0]  key_reg[4];
	logic [127:0] iv_reg = '0;
	logic [127:0] ctr_val = '0;
	logic [127:0] rkey[15];
	logic [7:0]   sb[256];

	function automatic logic [7:0] xt(logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= a;
			a = xt(a);
		end
		return p;
	endfunction

	function automatic logic [7:0] rl(logic [7:0] v, int n);
		return 8'((v << n) | (v >> (8 - n)));
	endfunction

	function automatic logic [31:0] subw(logic [31:0] w);
		return {sb[w[31:24]], sb[w[23:16]], sb[w[15:8]], sb[w[7:0]]};
	endfunction

	// Build the round keys from the shadow key
	function automatic void expand_round_keys();
		logic [31:0] w[60];
		logic [31:0] t;
		logic [7:0]  rc;
		rc = 8'h01;
		for (int i = 0; i < 8; i++)
			w[i] = (i % 2 == 0) ? key_reg[i / 2][63:32] : key_reg[i / 2][31:0];
		for (int i = 8; i < 60; i++) begin
			t = w[i - 1];
			if (i % 8 == 0) begin
				t = subw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = xt(rc);
			end else if (i % 8 == 4) begin
				t = subw(t);
			end
			w[i] = w[i - 8] ^ t;
		end
		for (int r = 0; r < 15; r++)
			rkey[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
	endfunction

	function automatic logic [127:0] encrypt_block(logic [127:0] blk);
		logic [7:0] s[16];
		logic [7:0] t[16];
		logic [7:0] a0, a1, a2, a3, sm;
		for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8] ^ rkey[0][127 - 8 * i -: 8];
		for (int r = 1; r <= 14; r++) begin
			for (int c = 0; c < 4; c++)
				for (int w = 0; w < 4; w++) t[w + 4 * c] = sb[s[w + 4 * ((c + w) % 4)]];
			s = t;
			if (r < 14) begin
				for (int c = 0; c < 4; c++) begin
					a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
					sm = a0 ^ a1 ^ a2 ^ a3;
					s[4 * c]     = a0 ^ sm ^ xt(a0 ^ a1);
					s[4 * c + 1] = a1 ^ sm ^ xt(a1 ^ a2);
					s[4 * c + 2] = a2 ^ sm ^ xt(a2 ^ a3);
					s[4 * c + 3] = a3 ^ sm ^ xt(a3 ^ a0);
				end
			end
			for (int i = 0; i < 16; i++) s[i] ^= rkey[r][127 - 8 * i -: 8];
		end
		for (int i = 0; i < 16; i++) blk[127 - 8 * i -: 8] = s[i];
		return blk;
	endfunction

	// On a start reload the counter and expand the keys; encrypt the counter, mask the valid bytes, advance the counter
	function automatic cipher_out_t ctr_crypt(chunk_t c);
		cipher_out_t r;
		logic [127:0] ks, data, res;
		int n;
		if (c.st) begin
			ctr_val = iv_reg;
			expand_round_keys();
		end
		ks = encrypt_block(ctr_val);
		data = {c.hi, c.lo};
		res = '0;
		n = (c.nb > 16) ? 16 : c.nb;
		for (int i = 0; i < n; i++)
			res[127 - 8 * i -: 8] = data[127 - 8 * i -: 8] ^ ks[127 - 8 * i -: 8];
		ctr_val = ctr_val + 128'd1;
		r.hi = res[127:64];
		r.lo = res[63:0];
		r.nb = c.nb;
		return r;
	endfunction

	// Build the S-box from the field inverse and the affine map
	initial begin
		logic [7:0] inv;
		for (int x = 0; x < 256; x++) begin
			inv = 8'h00;
			for (int y = 1; y < 256; y++)
				if (gmul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
			sb[x] = inv ^ rl(inv, 1) ^ rl(inv, 2) ^ rl(inv, 3) ^ rl(inv, 4) ^ 8'h63;
		end
		for (int i = 0; i < 4; i++) key_reg[i] = '0;
	end

	// Drive chunk beats and receiver stalls at the falling edge
	always @(negedge clk) begin
		chunk_t c;
		if (!in_valid || in_fire) begin
			if (arst_n && chunk_q.size() > 0 && $urandom_range(99) >= in_idle) begin
				c = chunk_q.pop_front();
				chunk_high <= c.hi;
				chunk_low <= c.lo;
				chunk_bytes <= c.nb;
				start_req <= c.st;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= arst_n && ($urandom_range(99) >= out_idle);
	end

	// Track accepted beats, predict, and check results
	always @(posedge clk) begin
		chunk_t c;
		cipher_out_t e;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			in_fire <= in_valid && in_ready;
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_KEY0:    key_reg[0] = cfg_data;
					REG_KEY1:    key_reg[1] = cfg_data;
					REG_KEY2:    key_reg[2] = cfg_data;
					REG_KEY3:    key_reg[3] = cfg_data;
					REG_IV_HIGH: iv_reg[127:64] = cfg_data;
					REG_IV_LOW:  iv_reg[63:0] = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				c.hi = chunk_high;
				c.lo = chunk_low;
				c.nb = chunk_bytes;
				c.st = start_req;
				cipher_q.push_back(ctr_crypt(c));
			end
			if (out_valid && out_ready) begin
				if (cipher_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %h %h %0d", result_high, result_low,
							result_bytes);
				end else begin
					e = cipher_q.pop_front();
					if (e.hi !== result_high || e.lo !== result_low || e.nb !== result_bytes) begin
						mismatches++;
						if (mismatches <= 10)
							$display("exp %h %h %0d got %h %h %0d", e.hi, e.lo, e.nb,
								result_high, result_low, result_bytes);
					end
				end
			end
		end
	end

	task automatic cfg_put(reg_idx_t idx, logic [63:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_regs(logic [63:0] k0, k1, k2, k3, ivh, ivl);
		cfg_put(REG_KEY0, k0);
		cfg_put(REG_KEY1, k1);
		cfg_put(REG_KEY2, k2);
		cfg_put(REG_KEY3, k3);
		cfg_put(REG_IV_HIGH, ivh);
		cfg_put(REG_IV_LOW, ivl);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Block until every beat is sent and every result has come back
	task automatic drain();
		do @(posedge clk);
		while (chunk_q.size() != 0 || in_valid || cipher_q.size() != 0);
	endtask

	task automatic push_chunk(logic [63:0] hi, lo, logic [4:0] nb, logic st);
		chunk_t c;
		c.hi = hi; c.lo = lo; c.nb = nb; c.st = st;
		chunk_q.push_back(c);
	endtask

	function automatic logic [63:0] r64();
		return {$urandom, $urandom};
	endfunction

	// Queue one message: start, full chunks, possibly a short tail, some noise
	task automatic push_message();
		int len;
		int pick;
		logic [4:0] nb;
		len = $urandom_range(1, 10);
		for (int i = 0; i < len; i++) begin
			nb = 5'd16;
			pick = $urandom_range(99);
			if (i == len - 1 && pick < 60) nb = 5'($urandom_range(1, 16));
			else if (pick < 4) nb = 5'd0;
			else if (pick < 8) nb = 5'($urandom_range(17, 31));
			else if (pick < 12) nb = 5'($urandom_range(1, 15));
			push_chunk(r64(), r64(), nb, i == 0 || $urandom_range(99) < 2);
		end
	endtask

	initial begin
		int sent;
		int pend;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: zero key and IV, every length class
		load_regs('0, '0, '0, '0, '0, '0);
		push_chunk('0, '0, 5'd16, 1'b1);
		push_chunk('1, '1, 5'd16, 1'b0);
		push_chunk('1, '1, 5'd1, 1'b0);
		push_chunk('1, '1, 5'd0, 1'b0);
		push_chunk('1, '1, 5'd31, 1'b0);
		push_chunk('1, '1, 5'd17, 1'b0);
		push_chunk(r64(), r64(), 5'd7, 1'b0);
		push_chunk(r64(), r64(), 5'd15, 1'b0);
		push_chunk(r64(), r64(), 5'd8, 1'b1);
		push_chunk(r64(), r64(), 5'd9, 1'b0);
		drain();

		// Directed: all-ones key and IV, counter wraps to zero
		load_regs('1, '1, '1, '1, '1, '1);
		push_chunk('0, '0, 5'd16, 1'b1);
		push_chunk('1, '1, 5'd16, 1'b0);
		push_chunk(r64(), r64(), 5'd16, 1'b0);
		drain();

		// Directed: carry from the low word into the high word
		load_regs(r64(), r64(), r64(), r64(), 64'h0123456789abcdef, '1);
		push_chunk(r64(), r64(), 5'd16, 1'b1);
		push_chunk(r64(), r64(), 5'd16, 1'b0);
		push_chunk(r64(), r64(), 5'd3, 1'b0);
		drain();

		// Random: three stall profiles, several key settings each
		for (int m = 0; m < 3; m++) begin
			in_idle = (m == 0) ? 31 : (m == 1) ? 84 : 0;
			out_idle = (m == 0) ? 84 : (m == 1) ? 31 : 0;
			for (int s = 0; s < 4; s++) begin
				load_regs(r64(), r64(), r64(), r64(), r64(),
					(s == 3) ? 64'hffffffff_fffffffe : r64());
				sent = 0;
				while (sent < 100) begin
					pend = chunk_q.size();
					push_message();
					sent = sent + chunk_q.size() - pend;
					// hold off now and then until the pipe is empty
					if ($urandom_range(99) < 10) drain();
					while (chunk_q.size() > 8) @(negedge clk);
				end
				drain();
			end
		end

		repeat (80) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* files.f */
hdl/aes_pkg.sv
hdl/aes_ram.sv
hdl/aes_lane.sv
hdl/aes_keyexp.sv
hdl/aes256_ctr_cipher_core.sv
bench/tb_aes256_ctr_cipher_core.sv
